FILE: hdl/trbs_pkg.sv
package trbs_pkg;

   localparam int COPIES = 3;
   localparam int BYTE_W = 8;
   localparam int ROW_W  = COPIES * BYTE_W;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [2:0]        op_type;

   localparam op_type OP_READ  = 3'd0;
   localparam op_type OP_WRITE = 3'd1;
   localparam op_type OP_CLEAR = 3'd2;
   localparam op_type OP_SCRUB = 3'd3;
   localparam op_type OP_RAW   = 3'd4;

   localparam byte_type ERASED_BYTE = 8'hFF;
   localparam byte_type NO_MAJORITY = 8'hFF;
   localparam row_type  ERASED_ROW  = {COPIES{ERASED_BYTE}};

   // Copy k of a byte sits in bits [8k+7:8k] of its row.
   function automatic byte_type vote(row_type row);
      byte_type a;
      byte_type b;
      byte_type c;
      a = row[7:0];
      b = row[15:8];
      c = row[23:16];
      if (a == b || a == c) begin
         vote = a;
      end else if (b == c) begin
         vote = b;
      end else begin
         vote = NO_MAJORITY;
      end
   endfunction

   // Repairs a lone differing copy; with no two copies agreeing the row is zeroed.
   function automatic row_type scrub_row(row_type row);
      byte_type a;
      byte_type b;
      byte_type c;
      a = row[7:0];
      b = row[15:8];
      c = row[23:16];
      if (a == b || a == c) begin
         scrub_row = {COPIES{a}};
      end else if (b == c) begin
         scrub_row = {COPIES{b}};
      end else begin
         scrub_row = '0;
      end
   endfunction

endpackage

FILE: hdl/trbs_ram.sv
module trbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/triple_redundant_byte_store.sv
// Triple-redundant byte store. Every logical byte is kept as three copies in one
// row of a synchronous RAM; reads return the majority of the copies.
// Request channel (req_valid/req_stall) carries op, index, count, value and
// copy_select; a word is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid/rsp_stall) gives read_data and success, one word
// per request, held in an output register until the receiver stops stalling.
// The user must write the size register over csr_valid/csr_ready only while
// the block is idle; the block itself does not enforce it. A read, write or raw
// write inside the logical size passes through ISSUE (RAM read), EXEC (modify
// and write back) and DONE (load of the response) before it returns to IDLE
// and the next request is accepted. A refused request skips the RAM and goes
// from ISSUE straight to DONE. Clear and scrub visit one row per cycle through
// the single RAM read port, staying in EXEC up to the last row in the range; an
// empty range goes from ISSUE straight to DONE. After reset the block sweeps
// every RAM row, filling it with 255, and holds req_stall high meanwhile; the
// size register returns to zero. A stalled response does not block the next
// request; the finished result of that request waits in its last state until
// the output register is free.
module triple_redundant_byte_store #(
   parameter int CAPACITY    = 256,
   parameter int BLOCK_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [9:0] req_index,
   input  logic [9:0] req_count,
   input  logic [7:0] req_value,
   input  logic [1:0] req_copy_select,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_success,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_size_in_blocks
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SIZE_W = $clog2(CAPACITY + 1);
   localparam int PROD_W = 4 + $clog2(BLOCK_BYTES + 1);
   localparam int CMP_W  = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;
   localparam int PW     = (SIZE_W > 11) ? SIZE_W : 11;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic [PW-1:0]           end_ff, end_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   trbs_pkg::op_type        op_ff, op_in;
   trbs_pkg::byte_type      val_ff, val_in;
   logic [1:0]              sel_ff, sel_in;
   logic                    ok_ff, ok_in;
   trbs_pkg::byte_type      rd_ff, rd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   trbs_pkg::byte_type      rsp_data_ff, rsp_data_in;
   logic                    rsp_ok_ff, rsp_ok_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   trbs_pkg::row_type       wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   trbs_pkg::row_type       rd_data;

   logic [PROD_W-1:0]       prod;
   logic [PW-1:0]           idx_ext;
   logic [PW-1:0]           size_ext;
   logic [PW-1:0]           clr_end;
   logic                    in_range;
   logic [PW-1:0]           ptr_next;
   trbs_pkg::byte_type      voted;

   trbs_ram #(
      .WIDTH(trbs_pkg::ROW_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Logical size, saturated at the capacity, is worked out once per register write.
   assign prod    = PROD_W'(csr_size_in_blocks) * PROD_W'(BLOCK_BYTES);
   assign size_in = (CMP_W'(prod) > CMP_W'(CAPACITY)) ? SIZE_W'(CAPACITY) : SIZE_W'(prod);
   assign csr_ready = 1'b1;

   assign idx_ext  = PW'(req_index);
   assign size_ext = PW'(size_ff);
   assign in_range = idx_ext < size_ext;
   assign clr_end  = ((idx_ext + PW'(req_count)) > size_ext) ? size_ext
                                                               : (idx_ext + PW'(req_count));
   assign ptr_next = ptr_ff + PW'(1);
   assign voted    = trbs_pkg::vote(rd_data);

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_success   = rsp_ok_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      sel_in       = sel_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[ADDR_W-1:0];
      wr_data      = trbs_pkg::ERASED_ROW;
      rd_addr      = ptr_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_next;
            if (ptr_ff == PW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_op;
               val_in = req_value;
               sel_in = req_copy_select;
               ptr_in = idx_ext;
               end_in = idx_ext + PW'(1);
               rd_in  = '0;
               ok_in  = 1'b0;
               case (req_op)
                  trbs_pkg::OP_READ: begin
                     ok_in = in_range;
                     rd_in = trbs_pkg::NO_MAJORITY;
                  end
                  trbs_pkg::OP_WRITE: begin
                     ok_in = in_range;
                  end
                  trbs_pkg::OP_CLEAR: begin
                     ok_in  = in_range;
                     end_in = clr_end;
                  end
                  trbs_pkg::OP_SCRUB: begin
                     ok_in  = 1'b1;
                     ptr_in = '0;
                     end_in = size_ext;
                  end
                  trbs_pkg::OP_RAW: begin
                     ok_in = in_range && (req_copy_select < 2'(trbs_pkg::COPIES));
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (ok_ff && (ptr_ff < end_ff)) begin
               state_in = S_EXEC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EXEC: begin
            case (op_ff)
               trbs_pkg::OP_READ: begin
                  rd_in = voted;
               end
               trbs_pkg::OP_WRITE: begin
                  wr_en   = (voted != val_ff);
                  wr_data = {trbs_pkg::COPIES{val_ff}};
               end
               trbs_pkg::OP_CLEAR: begin
                  wr_en   = (voted != '0);
                  wr_data = '0;
               end
               trbs_pkg::OP_SCRUB: begin
                  wr_en   = 1'b1;
                  wr_data = trbs_pkg::scrub_row(rd_data);
               end
               trbs_pkg::OP_RAW: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data;
                  case (sel_ff)
                     2'd0:    wr_data[7:0]   = val_ff;
                     2'd1:    wr_data[15:8]  = val_ff;
                     2'd2:    wr_data[23:16] = val_ff;
                     default: wr_data        = rd_data;
                  endcase
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
            // The next row is fetched while this one is written back.
            rd_addr = ptr_next[ADDR_W-1:0];
            ptr_in  = ptr_next;
            if (ptr_next >= end_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ff;
               rsp_ok_in    = ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            size_ff <= size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      sel_ff      <= sel_in;
      ok_ff       <= ok_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   a_write_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC || state_ff == S_INIT))
      else $error("RAM written outside the fill sweep or an operation");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (ptr_ff < end_ff && ptr_ff < PW'(CAPACITY)))
      else $error("Row pointer past the end of the range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("Response raised outside the completion state");

   a_fill_complete: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_INIT && state_ff == S_IDLE) |->
         ($past(ptr_ff) == PW'(CAPACITY - 1)))
      else $error("Fill sweep left before the last row");

endmodule
